// ----- design/mrc_pkg.sv -----
`default_nettype none

package mrc_pkg;

    // Longest frame served; byte count saturates one above it.
    localparam int unsigned MAX_FRAME = 256;
    localparam int unsigned CNT_W     = $clog2(MAX_FRAME + 2);
    localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(7);

    localparam int unsigned HDR_BYTES = 6;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FC_FIRST = 8'd2;
    localparam logic [7:0] FC_LAST  = 8'd4;

    // Register indexes on the APB port (byte address = 4 * index).
    localparam logic REG_LOW_ADDR  = 1'b0;
    localparam logic REG_HIGH_ADDR = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPTED         = 3'd0,
        ST_SHORT            = 3'd1,
        ST_LONG             = 3'd2,
        ST_CRC_ERROR        = 3'd3,
        ST_ADDR_UNSERVED    = 3'd4,
        ST_FUNC_UNSUPPORTED = 3'd5
    } status_t;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] crc_error_total;
        logic [15:0] register_quantity;
        logic [15:0] start_register;
        logic [7:0]  function_code;
        logic [7:0]  unit_address;
        status_t     frame_status;
    } result_t;

    typedef struct packed {
        logic [7:0] low_addr;
        logic [7:0] high_addr;
    } cfg_t;

    // One byte through the reflected CRC-16, bit at a time.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/modbus_rtu_request_checker.sv -----
// Path: a last byte is held in the input register, then its verdict is loaded into the
// result register and shows on m_tvalid (one input register, one result register).
// Throughput: one byte per cycle; a last byte waits only while an unread verdict is
// held and m_tready is low. Non-final bytes never wait on the result side.
// Reset: aresetn synchronous, active low; clears frame state, CRC error count and
// restores the unit address range to 1..4. No clearing pass.
`default_nettype none

module modbus_rtu_request_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input byte stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // frame_end
    // verdict stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // [2:0] frame_status, [10:3] unit_address,
                                        // [18:11] function_code, [34:19] start_register,
                                        // [50:35] register_quantity,
                                        // [82:51] crc_error_total, [87:83] zero
    // APB config: 0x0 lowest unit address, 0x4 highest unit address
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    mrc_pkg::cfg_t     cfg;
    mrc_pkg::in_item_t item;
    mrc_pkg::result_t  result;
    logic              item_valid;
    logic              advance;

    // A held word moves on unless it is a last byte and the result register is still full.
    assign advance = item_valid && (!item.frame_end || !m_tvalid || m_tready);

    mrc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // CRC fold, header capture, length count and verdict
    mrc_frame_check u_check (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    mrc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && item.frame_end),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- design/mrc_cfg_regs.sv -----
`default_nettype none

module mrc_cfg_regs (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mrc_pkg::cfg_t     cfg
);

    logic [7:0] low_addr_reg;
    logic [7:0] high_addr_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_addr_reg  <= 8'd1;
            high_addr_reg <= 8'd4;
        end else if (wr_en) begin
            unique case (paddr[2])
                mrc_pkg::REG_LOW_ADDR:  low_addr_reg  <= pwdata[7:0];
                mrc_pkg::REG_HIGH_ADDR: high_addr_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mrc_pkg::REG_LOW_ADDR:  prdata = {24'd0, low_addr_reg};
            mrc_pkg::REG_HIGH_ADDR: prdata = {24'd0, high_addr_reg};
            default:                prdata = 32'd0;
        endcase
    end

    assign cfg.low_addr  = low_addr_reg;
    assign cfg.high_addr = high_addr_reg;

endmodule

`default_nettype wire

// ----- design/mrc_in_stage.sv -----
`default_nettype none

module mrc_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          advance,   // held word consumed this cycle
    output logic               item_valid,
    output mrc_pkg::in_item_t  item
);

    logic              valid_reg;
    logic              valid_next;
    mrc_pkg::in_item_t item_reg;

    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.rx_byte   <= s_tdata;
            item_reg.frame_end <= s_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- design/mrc_frame_check.sv -----
`default_nettype none

module mrc_frame_check (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire mrc_pkg::in_item_t item,
    input  wire mrc_pkg::cfg_t     cfg,
    output mrc_pkg::result_t       result
);

    logic [15:0]               crc_reg;
    logic [15:0]               crc_next;
    logic [mrc_pkg::CNT_W-1:0] count_reg;
    logic [mrc_pkg::CNT_W-1:0] count_next;
    logic [7:0]                hdr_reg  [mrc_pkg::HDR_BYTES];
    logic [7:0]                hdr_next [mrc_pkg::HDR_BYTES];
    logic [7:0]                tail0_reg;
    logic [7:0]                tail1_reg;
    logic [31:0]               err_reg;
    logic [31:0]               err_next;
    logic [15:0]               crc_rx;
    mrc_pkg::status_t          status;

    // Trailing two bytes are held back and only folded once a newer byte pushes them out.
    assign crc_next = (count_reg >= mrc_pkg::CNT_W'(2))
                    ? mrc_pkg::crc_fold(crc_reg, tail0_reg) : crc_reg;
    assign count_next = (count_reg < mrc_pkg::CNT_SAT)
                      ? count_reg + mrc_pkg::CNT_W'(1) : count_reg;

    always_comb begin
        for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) begin
            hdr_next[i] = (count_reg == mrc_pkg::CNT_W'(i)) ? item.rx_byte : hdr_reg[i];
        end
    end

    // Received CRC: low byte second-last, high byte last.
    assign crc_rx = {item.rx_byte, tail1_reg};

    always_comb begin
        priority if (count_next < mrc_pkg::MIN_FRAME) begin
            status = mrc_pkg::ST_SHORT;
        end else if (count_next > mrc_pkg::CNT_MAX) begin
            status = mrc_pkg::ST_LONG;
        end else if (crc_rx != crc_next) begin
            status = mrc_pkg::ST_CRC_ERROR;
        end else if (hdr_next[0] < cfg.low_addr || hdr_next[0] > cfg.high_addr) begin
            status = mrc_pkg::ST_ADDR_UNSERVED;
        end else if (hdr_next[1] < mrc_pkg::FC_FIRST || hdr_next[1] > mrc_pkg::FC_LAST) begin
            status = mrc_pkg::ST_FUNC_UNSUPPORTED;
        end else begin
            status = mrc_pkg::ST_ACCEPTED;
        end
    end

    always_comb begin
        err_next = err_reg;
        if (status == mrc_pkg::ST_CRC_ERROR && err_reg != 32'hFFFF_FFFF) begin
            err_next = err_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= mrc_pkg::CRC_INIT;
            count_reg <= '0;
            tail0_reg <= 8'd0;
            tail1_reg <= 8'd0;
            err_reg   <= 32'd0;
            for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) begin
                hdr_reg[i] <= 8'd0;
            end
        end else if (advance) begin
            if (item.frame_end) begin
                crc_reg   <= mrc_pkg::CRC_INIT;
                count_reg <= '0;
                tail0_reg <= 8'd0;
                tail1_reg <= 8'd0;
                err_reg   <= err_next;
                for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) begin
                    hdr_reg[i] <= 8'd0;
                end
            end else begin
                crc_reg   <= crc_next;
                count_reg <= count_next;
                tail0_reg <= tail1_reg;
                tail1_reg <= item.rx_byte;
                for (int i = 0; i < mrc_pkg::HDR_BYTES; i++) begin
                    hdr_reg[i] <= hdr_next[i];
                end
            end
        end
    end

    assign result.frame_status      = status;
    assign result.unit_address      = hdr_next[0];
    assign result.function_code     = hdr_next[1];
    assign result.start_register    = {hdr_next[2], hdr_next[3]};
    assign result.register_quantity = {hdr_next[4], hdr_next[5]};
    assign result.crc_error_total   = err_next;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= mrc_pkg::CNT_SAT)
        else $error("byte count past saturation");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item.frame_end |=> count_reg == '0 && crc_reg == mrc_pkg::CRC_INIT)
        else $error("frame state not cleared after last byte");

    a_err_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> err_reg >= $past(err_reg))
        else $error("crc error counter went down");

endmodule

`default_nettype wire

// ----- design/mrc_out_stage.sv -----
`default_nettype none

module mrc_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire mrc_pkg::result_t result,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [87:0]           m_tdata
);

    logic             valid_reg;
    logic             valid_next;
    mrc_pkg::result_t result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, result_reg};

endmodule

`default_nettype wire
